FILE: design/ofh_pkg.sv
`default_nettype none

package ofh_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int HPOS_W   = 9;
   localparam int PROG_W   = 9;

   localparam int MAX_CANDIDATES_DEF = 8;
   localparam int BUFFER_DEPTH_DEF   = 512;
   localparam int MAX_RESULTS        = 8;

   localparam logic [BYTE_W-1:0] HEADER_BYTE   = 8'h55;
   localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'hFF;

   localparam logic [PROG_W-1:0] DEST_OFS   = 9'd1;
   localparam logic [PROG_W-1:0] SRC_OFS    = 9'd2;
   localparam logic [PROG_W-1:0] CMD_OFS    = 9'd3;
   localparam logic [PROG_W-1:0] LEN1_OFS   = 9'd4;
   localparam logic [PROG_W-1:0] LEN2_OFS   = 9'd5;
   localparam logic [PROG_W-1:0] CHECK_BASE = 9'd6;

   typedef enum logic [STATUS_W-1:0] {
      FRAME_OK        = 2'd0,
      FRAME_LEN_FAULT = 2'd1,
      FRAME_SUM_FAULT = 2'd2
   } frame_status_type;

   typedef struct packed {
      logic start;
      logic step;
      logic finish;
   } ofh_cmd_type;

   typedef struct packed {
      logic empty;
      logic at_last;
      logic hold;
   } ofh_stat_type;

endpackage

`default_nettype wire

FILE: design/ofh_if.sv
`default_nettype none

interface ofh_req_if import ofh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ofh_rsp_if import ofh_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] frame_status;
   logic [BYTE_W-1:0]   dest_addr;
   logic [BYTE_W-1:0]   source_addr;
   logic [BYTE_W-1:0]   command_code;
   logic [BYTE_W-1:0]   payload_length;
   logic [HPOS_W-1:0]   header_position;
   logic                last_result;

   modport source (
      output valid, output frame_status, output dest_addr, output source_addr,
      output command_code, output payload_length, output header_position,
      output last_result, input ready
   );
   modport sink (
      input valid, input frame_status, input dest_addr, input source_addr,
      input command_code, input payload_length, input header_position,
      input last_result, output ready
   );
endinterface

`default_nettype wire

FILE: design/ofh_ctrl.sv
`default_nettype none

module ofh_ctrl import ofh_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire ofh_stat_type stat,
   output ofh_cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_WALK   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = stat.empty ? S_FINISH : S_WALK;
            end
         end
         S_WALK: begin
            cmd.step = 1'b1;
            if (!stat.hold && stat.at_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/ofh_datapath.sv
`default_nettype none

module ofh_datapath import ofh_pkg::*; #(
   parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
   parameter int BUFFER_DEPTH   = BUFFER_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [BYTE_W-1:0] csr_wdata,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  wire ofh_cmd_type       cmd,
   output ofh_stat_type           stat,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [STATUS_W-1:0]    rsp_frame_status,
   output logic [BYTE_W-1:0]      rsp_dest_addr,
   output logic [BYTE_W-1:0]      rsp_source_addr,
   output logic [BYTE_W-1:0]      rsp_command_code,
   output logic [BYTE_W-1:0]      rsp_payload_length,
   output logic [HPOS_W-1:0]      rsp_header_position,
   output logic                   rsp_last_result
);

   localparam int IW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int CW = $clog2(MAX_CANDIDATES + 1);
   localparam int PW = $clog2(BUFFER_DEPTH);
   localparam int RW = $clog2(MAX_RESULTS + 1);

   logic [PROG_W-1:0] prog_ff  [MAX_CANDIDATES];
   logic [BYTE_W-1:0] len1_ff  [MAX_CANDIDATES];
   logic [BYTE_W-1:0] len2_ff  [MAX_CANDIDATES];
   logic [BYTE_W-1:0] sum_ff   [MAX_CANDIDATES];
   logic [BYTE_W-1:0] dest_ff  [MAX_CANDIDATES];
   logic [BYTE_W-1:0] src_ff   [MAX_CANDIDATES];
   logic [BYTE_W-1:0] cmd_ff   [MAX_CANDIDATES];
   logic [PW-1:0]     start_ff [MAX_CANDIDATES];

   logic [PROG_W-1:0] prog_in;
   logic [BYTE_W-1:0] len1_in;
   logic [BYTE_W-1:0] len2_in;
   logic [BYTE_W-1:0] sum_in;
   logic [BYTE_W-1:0] dest_in;
   logic [BYTE_W-1:0] src_in;
   logic [BYTE_W-1:0] cmd_in;
   logic [PW-1:0]     start_in;
   logic              slot_we;

   logic [BYTE_W-1:0]         max_len_ff, max_len_in;
   logic [BYTE_W-1:0]         byte_ff, byte_in;
   logic [PW-1:0]             pos_ff, pos_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             wr_ff, wr_in;
   logic [RW-1:0]             nres_ff, nres_in;
   logic [MAX_CANDIDATES-1:0] pend_ff, pend_in, pend_start;

   logic                      out_valid_ff, out_valid_in;
   frame_status_type          out_status_ff, out_status_in;
   logic [BYTE_W-1:0]         out_dest_ff, out_dest_in;
   logic [BYTE_W-1:0]         out_src_ff, out_src_in;
   logic [BYTE_W-1:0]         out_cmd_ff, out_cmd_in;
   logic [BYTE_W-1:0]         out_len_ff, out_len_in;
   logic [HPOS_W-1:0]         out_hpos_ff, out_hpos_in;
   logic                      out_last_ff, out_last_in;

   logic [PROG_W-1:0]      cur_prog;
   logic                   cur_done;
   logic                   emit;
   logic                   out_free;
   logic                   last_now;
   logic [CW:0]            idx_next;
   logic [PW+HPOS_W-1:0]   hpos_wide;
   frame_status_type       cur_status;
   logic                   take_step;

   always_comb begin
      for (int k = 0; k < MAX_CANDIDATES; k++) begin
         pend_start[k] = (CW'(k) < count_ff) &&
                         (prog_ff[k] + 9'd1 == {1'b0, len2_ff[k]} + CHECK_BASE);
      end
   end

   assign cur_prog  = prog_ff[idx_ff] + 9'd1;
   assign cur_done  = (cur_prog == {1'b0, len2_ff[idx_ff]} + CHECK_BASE);
   assign emit      = cur_done && (nres_ff < RW'(MAX_RESULTS));
   assign out_free  = !out_valid_ff || rsp_ready;
   assign idx_next  = (CW + 1)'(idx_ff) + 1'b1;
   assign last_now  = ((pend_ff & ~(MAX_CANDIDATES'(1) << idx_ff)) == '0) ||
                      (nres_ff == RW'(MAX_RESULTS - 1));
   assign hpos_wide = (PW + HPOS_W)'(start_ff[idx_ff]);
   assign take_step = cmd.step && !(emit && !out_free);

   always_comb begin
      if (len1_ff[idx_ff] > max_len_ff || len1_ff[idx_ff] != len2_ff[idx_ff]) begin
         cur_status = FRAME_LEN_FAULT;
      end else if (sum_ff[idx_ff] != byte_ff) begin
         cur_status = FRAME_SUM_FAULT;
      end else begin
         cur_status = FRAME_OK;
      end
   end

   assign stat.empty   = (count_ff == '0);
   assign stat.at_last = (idx_next == {1'b0, count_ff});
   assign stat.hold    = emit && !out_free;

   always_comb begin
      slot_we  = 1'b0;
      prog_in  = cur_prog;
      len1_in  = len1_ff[idx_ff];
      len2_in  = len2_ff[idx_ff];
      sum_in   = (cur_prog != '0) ? sum_ff[idx_ff] + byte_ff : sum_ff[idx_ff];
      dest_in  = dest_ff[idx_ff];
      src_in   = src_ff[idx_ff];
      cmd_in   = cmd_ff[idx_ff];
      start_in = start_ff[idx_ff];
      if (cur_prog == DEST_OFS) begin
         dest_in = byte_ff;
      end
      if (cur_prog == SRC_OFS) begin
         src_in = byte_ff;
      end
      if (cur_prog == CMD_OFS) begin
         cmd_in = byte_ff;
      end
      if (cur_prog == LEN1_OFS) begin
         len1_in = byte_ff;
      end
      if (cur_prog == LEN2_OFS) begin
         len2_in = byte_ff;
      end
      if (take_step && !cur_done) begin
         slot_we = 1'b1;
      end
      if (cmd.finish && byte_ff == HEADER_BYTE && wr_ff < CW'(MAX_CANDIDATES)) begin
         slot_we  = 1'b1;
         prog_in  = '0;
         len1_in  = '0;
         len2_in  = '0;
         sum_in   = '0;
         dest_in  = '0;
         src_in   = '0;
         cmd_in   = '0;
         start_in = pos_ff;
      end
   end

   always_comb begin
      max_len_in    = csr_we ? csr_wdata : max_len_ff;
      byte_in       = byte_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      nres_in       = nres_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_dest_in   = out_dest_ff;
      out_src_in    = out_src_ff;
      out_cmd_in    = out_cmd_ff;
      out_len_in    = out_len_ff;
      out_hpos_in   = out_hpos_ff;
      out_last_in   = out_last_ff;
      if (cmd.start) begin
         byte_in = rx_byte;
         idx_in  = '0;
         wr_in   = '0;
         nres_in = '0;
         pend_in = pend_start;
      end
      if (take_step) begin
         pend_in[idx_ff] = 1'b0;
         idx_in          = idx_next[IW-1:0];
         if (emit) begin
            out_valid_in  = 1'b1;
            out_status_in = cur_status;
            out_dest_in   = dest_ff[idx_ff];
            out_src_in    = src_ff[idx_ff];
            out_cmd_in    = cmd_ff[idx_ff];
            out_len_in    = len1_ff[idx_ff];
            out_hpos_in   = hpos_wide[HPOS_W-1:0];
            out_last_in   = last_now;
            nres_in       = nres_ff + 1'b1;
         end
         if (!cur_done) begin
            wr_in = wr_ff + 1'b1;
         end
      end
      if (cmd.finish) begin
         if (byte_ff == HEADER_BYTE && wr_ff < CW'(MAX_CANDIDATES)) begin
            count_in = wr_ff + 1'b1;
         end else begin
            count_in = wr_ff;
         end
         pos_in = (pos_ff == PW'(BUFFER_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         prog_ff[wr_ff[IW-1:0]]  <= prog_in;
         len1_ff[wr_ff[IW-1:0]]  <= len1_in;
         len2_ff[wr_ff[IW-1:0]]  <= len2_in;
         sum_ff[wr_ff[IW-1:0]]   <= sum_in;
         dest_ff[wr_ff[IW-1:0]]  <= dest_in;
         src_ff[wr_ff[IW-1:0]]   <= src_in;
         cmd_ff[wr_ff[IW-1:0]]   <= cmd_in;
         start_ff[wr_ff[IW-1:0]] <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RESET;
         pos_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      idx_ff        <= idx_in;
      wr_ff         <= wr_in;
      nres_ff       <= nres_in;
      pend_ff       <= pend_in;
      out_status_ff <= out_status_in;
      out_dest_ff   <= out_dest_in;
      out_src_ff    <= out_src_in;
      out_cmd_ff    <= out_cmd_in;
      out_len_ff    <= out_len_in;
      out_hpos_ff   <= out_hpos_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_frame_status    = out_status_ff;
   assign rsp_dest_addr       = out_dest_ff;
   assign rsp_source_addr     = out_src_ff;
   assign rsp_command_code    = out_cmd_ff;
   assign rsp_payload_length  = out_len_ff;
   assign rsp_header_position = out_hpos_ff;
   assign rsp_last_result     = out_last_ff;

endmodule

`default_nettype wire

FILE: design/overlapping_frame_hunter_with_sum_check.sv
// Frame hunter for a received byte stream with an additive checksum.
// Each word on the req_ch channel is one received byte. Every header byte
// opens a frame candidate while the table has room, and up to MAX_CANDIDATES
// candidates are tracked at once in age order. Each word on the rsp_ch
// channel reports one completed frame: its status, header fields and header
// position; the last report caused by a byte carries last_result.
// The csr port writes the largest accepted payload length; the user must
// write it only while the block is idle, which the block does not enforce.
// A byte is handled in steps: it is accepted, the single slot update unit
// walks the candidate table oldest first, candidate by candidate, and a
// final step appends a new candidate and closes the byte. The next byte is
// accepted only after that final step.
// A report is loaded into the output register in the cycle after its
// candidate is visited.
// When the receiver stalls with a report still held, the walk stops at the
// next completing candidate until the register frees.
// Reset clears the candidate table, the receive position and the output,
// and sets the length limit to 255.
`default_nettype none

module overlapping_frame_hunter_with_sum_check import ofh_pkg::*; #(
   parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
   parameter int BUFFER_DEPTH   = BUFFER_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [BYTE_W-1:0] csr_wdata,
   ofh_req_if.sink                req_ch,
   ofh_rsp_if.source              rsp_ch
);

   ofh_cmd_type  cmd;
   ofh_stat_type stat;
   logic         req_ready;

   ofh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ofh_datapath #(
      .MAX_CANDIDATES (MAX_CANDIDATES),
      .BUFFER_DEPTH   (BUFFER_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .rx_byte             (req_ch.rx_byte),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_frame_status    (rsp_ch.frame_status),
      .rsp_dest_addr       (rsp_ch.dest_addr),
      .rsp_source_addr     (rsp_ch.source_addr),
      .rsp_command_code    (rsp_ch.command_code),
      .rsp_payload_length  (rsp_ch.payload_length),
      .rsp_header_position (rsp_ch.header_position),
      .rsp_last_result     (rsp_ch.last_result)
   );

   assign req_ch.ready = req_ready;

endmodule

`default_nettype wire

FILE: tb/overlapping_frame_hunter_with_sum_check_tb.sv
`timescale 1ns / 100ps

module overlapping_frame_hunter_with_sum_check_tb import ofh_pkg::*; ();

   localparam int NUM_SLOTS      = MAX_CANDIDATES_DEF;
   localparam int POS_DEPTH      = BUFFER_DEPTH_DEF;
   localparam int SETTLE_CYCLES  = 2 * (NUM_SLOTS + 2);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 80;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [PROG_W-1:0] ofs;
      logic [BYTE_W-1:0] len1;
      logic [BYTE_W-1:0] len2;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] dest;
      logic [BYTE_W-1:0] src;
      logic [BYTE_W-1:0] cmd;
      logic [HPOS_W-1:0] start;
   } frame_cand_type;

   typedef struct {
      frame_status_type  status;
      logic [BYTE_W-1:0] dest;
      logic [BYTE_W-1:0] src;
      logic [BYTE_W-1:0] cmd;
      logic [BYTE_W-1:0] len1;
      logic [HPOS_W-1:0] hpos;
      logic              last;
   } frame_report_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [BYTE_W-1:0] csr_wdata;

   ofh_req_if req_ch ();
   ofh_rsp_if rsp_ch ();

   overlapping_frame_hunter_with_sum_check dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   logic [BYTE_W-1:0] rx_stream[$];
   frame_report_type  frame_reports[$];
   frame_report_type  oldest_report;
   frame_cand_type    cands[NUM_SLOTS];
   int                live_count;
   logic [HPOS_W-1:0] rx_pos;
   logic [BYTE_W-1:0] max_len_limit;
   idle_mode_type     idle_mode;
   int                mismatch_count;
   int                quiet_cycles;

   localparam logic [BYTE_W-1:0] DIRECTED_BYTES [24] = '{
      HEADER_BYTE, HEADER_BYTE, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h57,
      HEADER_BYTE, 8'h80, 8'h7F, 8'h01, 8'h03, 8'h00, 8'h00,
      HEADER_BYTE, HEADER_BYTE, HEADER_BYTE, HEADER_BYTE, HEADER_BYTE,
      HEADER_BYTE, HEADER_BYTE, HEADER_BYTE, HEADER_BYTE
   };

   function automatic int sender_gap_pct(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER: return 49;
         IDLE_BOTH:   return 10;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(input idle_mode_type mode);
      case (mode)
         IDLE_RECEIVER: return 49;
         IDLE_BOTH:     return 10;
         default:       return 0;
      endcase
   endfunction

   // Advances every live candidate on one received word, oldest first, and
   // records reports for candidates at their checksum byte, MAX_RESULTS at most.
   task automatic hunt_byte(input logic [BYTE_W-1:0] b);
      int                slot;
      int                done_count;
      logic [PROG_W-1:0] ofs;
      frame_report_type  rep;
      frame_report_type  held;
      bit                have_held;
      slot = 0;
      done_count = 0;
      have_held = 1'b0;
      while (slot < live_count) begin
         ofs = cands[slot].ofs + 9'd1;
         cands[slot].ofs = ofs;
         if (ofs >= DEST_OFS && ofs <= LEN2_OFS) begin
            cands[slot].sum += b;
            case (ofs)
               DEST_OFS: cands[slot].dest = b;
               SRC_OFS:  cands[slot].src = b;
               CMD_OFS:  cands[slot].cmd = b;
               LEN1_OFS: cands[slot].len1 = b;
               default:  cands[slot].len2 = b;
            endcase
            slot++;
         end else if (ofs == CHECK_BASE + {1'b0, cands[slot].len2}) begin
            if (cands[slot].len1 > max_len_limit || cands[slot].len1 != cands[slot].len2)
               rep.status = FRAME_LEN_FAULT;
            else if (cands[slot].sum != b)
               rep.status = FRAME_SUM_FAULT;
            else
               rep.status = FRAME_OK;
            rep.dest = cands[slot].dest;
            rep.src  = cands[slot].src;
            rep.cmd  = cands[slot].cmd;
            rep.len1 = cands[slot].len1;
            rep.hpos = cands[slot].start;
            rep.last = 1'b0;
            if (done_count < MAX_RESULTS) begin
               if (have_held) frame_reports.push_back(held);
               held = rep;
               have_held = 1'b1;
               done_count++;
            end
            for (int j = slot; j + 1 < live_count; j++) cands[j] = cands[j + 1];
            cands[live_count - 1] = '0;
            live_count--;
         end else begin
            if (ofs > LEN2_OFS) cands[slot].sum += b;
            slot++;
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         frame_reports.push_back(held);
      end
      if (b == HEADER_BYTE && live_count < NUM_SLOTS) begin
         cands[live_count] = '0;
         cands[live_count].start = rx_pos;
         live_count++;
      end
      rx_pos = HPOS_W'((rx_pos + 1) % POS_DEPTH);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   function automatic int queue_frame();
      logic [BYTE_W-1:0] dest, src, cmd, len1, len2, data, sum;
      int                count;
      dest = 8'($urandom_range(0, 255));
      src  = 8'($urandom_range(0, 255));
      cmd  = 8'($urandom_range(0, 255));
      len2 = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 40))
                                         : 8'($urandom_range(0, 6));
      len1 = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : len2;
      sum = dest + src + cmd + len1 + len2;
      rx_stream.push_back(HEADER_BYTE);
      rx_stream.push_back(dest);
      rx_stream.push_back(src);
      rx_stream.push_back(cmd);
      rx_stream.push_back(len1);
      rx_stream.push_back(len2);
      for (int k = 0; k < len2; k++) begin
         data = 8'($urandom_range(0, 255));
         rx_stream.push_back(data);
         sum += data;
      end
      if ($urandom_range(0, 5) == 0) sum ^= 8'($urandom_range(1, 255));
      rx_stream.push_back(sum);
      count = 7 + len2;
      return count;
   endfunction

   function automatic int queue_noise();
      int count;
      count = $urandom_range(1, 4);
      for (int k = 0; k < count; k++)
         rx_stream.push_back(($urandom_range(0, 7) == 0) ? HEADER_BYTE
                                                          : 8'($urandom_range(0, 255)));
      return count;
   endfunction

   task automatic drain();
      while (rx_stream.size() != 0 || req_ch.valid || frame_reports.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_len(input logic [BYTE_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      max_len_limit = value;
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [BYTE_W-1:0] limit, input idle_mode_type mode);
      int added;
      write_max_len(limit);
      idle_mode = mode;
      added = 0;
      while (added < PHASE_BYTES) begin
         if ($urandom_range(0, 99) < 80) added += queue_frame();
         else added += queue_noise();
      end
      drain();
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      idle_mode      = IDLE_NONE;
      mismatch_count = 0;
      live_count     = 0;
      rx_pos         = '0;
      max_len_limit  = MAX_LEN_RESET;
      foreach (cands[k]) cands[k] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_BYTES[k]) rx_stream.push_back(DIRECTED_BYTES[k]);
      drain();

      run_phase(8'hFF, IDLE_SENDER);
      run_phase(8'h00, IDLE_RECEIVER);
      run_phase(8'($urandom_range(1, 6)), IDLE_BOTH);
      run_phase(8'($urandom_range(1, 254)), IDLE_NONE);

      if (mismatch_count == 0 && frame_reports.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (rx_stream.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct(idle_mode)) begin
            req_ch.valid   <= 1'b1;
            req_ch.rx_byte <= rx_stream.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Each accepted word is predicted before the report channel is checked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) hunt_byte(req_ch.rx_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frame_reports.size() == 0) begin
               $display("%0t: frame report with none expected, expected none, got dest %0h",
                        $time, rsp_ch.dest_addr);
               mismatch_count++;
            end else begin
               oldest_report = frame_reports.pop_front();
               check_field("frame_status", 16'(oldest_report.status), 16'(rsp_ch.frame_status));
               check_field("dest_addr", 16'(oldest_report.dest), 16'(rsp_ch.dest_addr));
               check_field("source_addr", 16'(oldest_report.src), 16'(rsp_ch.source_addr));
               check_field("command_code", 16'(oldest_report.cmd), 16'(rsp_ch.command_code));
               check_field("payload_length", 16'(oldest_report.len1),
                           16'(rsp_ch.payload_length));
               check_field("header_position", 16'(oldest_report.hpos),
                           16'(rsp_ch.header_position));
               check_field("last_result", 16'(oldest_report.last), 16'(rsp_ch.last_result));
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct(idle_mode));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word accepted for %0d cycles", $time, quiet_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

FILE: files.f
design/ofh_pkg.sv
design/ofh_if.sv
design/ofh_ctrl.sv
design/ofh_datapath.sv
design/overlapping_frame_hunter_with_sum_check.sv
tb/overlapping_frame_hunter_with_sum_check_tb.sv
